/* rtl/sao_pkg.sv */
// Shared constants, types and codes for the sandpile avalanche odometer.
package sao_pkg;

  // Grid and storage sizing
  localparam int GRID_SIDE     = 64;
  localparam int HEIGHT_BITS   = 16;
  localparam int ODOMETER_BITS = 32;

  localparam int ROW_BITS  = $clog2(GRID_SIDE);
  localparam int STEP_BITS = $clog2(GRID_SIDE + 2);
  localparam int AMT_BITS  = HEIGHT_BITS - 2;
  localparam int CENTER    = GRID_SIDE / 2;

  // Fixed field widths of the item ports
  localparam int CMD_W      = 2;
  localparam int FIELD_W    = 6;
  localparam int GRAINS_W   = 12;
  localparam int OUT_H_W    = 16;
  localparam int OUT_ODO_W  = 32;
  localparam int CORE_BITS  = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int SUM_BITS = (ODOMETER_BITS > AMT_BITS) ? ODOMETER_BITS : AMT_BITS;
  localparam int ADD_BITS = ((HEIGHT_BITS > GRAINS_W) ? HEIGHT_BITS : GRAINS_W) + 1;

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORE_UL = 2'd0,
    CFG_CORE_UR = 2'd1,
    CFG_CORE_LL = 2'd2,
    CFG_CORE_LR = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SWEEP,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [FIELD_W-1:0]  row;
    logic [FIELD_W-1:0]  column;
    logic [GRAINS_W-1:0] grains;
  } in_item_t;

  typedef struct packed {
    logic [OUT_H_W-1:0]   height;
    logic [OUT_ODO_W-1:0] topple_total;
    logic                 overflow;
  } out_item_t;

  // Row-sweep control broadcast to every column cell
  typedef struct packed {
    logic                clr_we;    // clear pass: write core/zero row
    logic                sweep;     // relaxation sweep in progress
    logic                proc;      // write back the row held in the cell
    logic                down_vld;  // read data is a real row below
    logic [ROW_BITS-1:0] rd_row;
    logic [ROW_BITS-1:0] wr_row;
  } sao_ctrl_t;

endpackage

/* rtl/sao_ram.sv */
// Generic simple dual-port RAM with registered read data.
module sao_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sao_cell.sv */
// One grid column: height/odometer storage and the per-row toppling step.
module sao_cell
  import sao_pkg::*;
(
  input  logic                     clk_i,
  input  sao_ctrl_t                ctrl_i,
  input  logic [CORE_BITS-1:0]     load_height_i,
  input  logic [GRAINS_W-1:0]      inject_i,
  input  logic [AMT_BITS-1:0]      amt_left_i,
  input  logic [AMT_BITS-1:0]      amt_right_i,
  output logic [AMT_BITS-1:0]      amt_o,
  output logic                     topple_o,
  output logic                     sat_o,
  output logic [HEIGHT_BITS-1:0]   rd_height_o,
  output logic [ODOMETER_BITS-1:0] rd_odo_o
);

  logic [HEIGHT_BITS+ODOMETER_BITS-1:0] rd_data, wr_data;
  logic [HEIGHT_BITS-1:0]   rd_h, inj_h, new_h;
  logic [ODOMETER_BITS-1:0] rd_odo, new_odo;
  logic [ADD_BITS-1:0]      inj_sum;
  logic                     inj_sat, we;
  logic [AMT_BITS-1:0]      amt_cur, amt_down;

  logic [HEIGHT_BITS-1:0]   cur_h_q, cur_h_d;
  logic [ODOMETER_BITS-1:0] cur_odo_q, cur_odo_d;
  logic [AMT_BITS-1:0]      amt_up_q, amt_up_d;

  sao_ram #(
    .WIDTH (HEIGHT_BITS + ODOMETER_BITS),
    .DEPTH (GRID_SIDE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ctrl_i.wr_row),
    .wdata_i (wr_data),
    .raddr_i (ctrl_i.rd_row),
    .rdata_o (rd_data)
  );

  assign rd_h   = rd_data[HEIGHT_BITS+ODOMETER_BITS-1:ODOMETER_BITS];
  assign rd_odo = rd_data[ODOMETER_BITS-1:0];

  // Grain injection on the incoming row, saturating
  always_comb begin
    inj_sum = ADD_BITS'(rd_h) + ADD_BITS'(inject_i);
    inj_sat = inj_sum > ADD_BITS'(HEIGHT_MAX);
    inj_h   = inj_sat ? HEIGHT_MAX : HEIGHT_BITS'(inj_sum);
  end

  assign amt_cur  = cur_h_q[HEIGHT_BITS-1:2];
  assign amt_down = ctrl_i.down_vld ? inj_h[HEIGHT_BITS-1:2] : '0;

  // Four inflows of at most max/4 each plus the remainder never exceed max
  always_comb begin
    new_h = HEIGHT_BITS'(amt_up_q) + HEIGHT_BITS'(amt_down) + HEIGHT_BITS'(amt_left_i)
          + HEIGHT_BITS'(amt_right_i) + HEIGHT_BITS'(cur_h_q[1:0]);
    new_odo = ODOMETER_BITS'(SUM_BITS'(cur_odo_q) + SUM_BITS'(amt_cur));
  end

  assign we      = ctrl_i.clr_we | ctrl_i.proc;
  assign wr_data = ctrl_i.clr_we ? {HEIGHT_BITS'(load_height_i), {ODOMETER_BITS{1'b0}}}
                                 : {new_h, new_odo};

  always_comb begin
    amt_up_d  = ctrl_i.proc ? amt_cur : '0;
    cur_h_d   = inj_h;
    cur_odo_d = rd_odo;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep) begin
      amt_up_q  <= amt_up_d;
      cur_h_q   <= cur_h_d;
      cur_odo_q <= cur_odo_d;
    end
  end

  assign amt_o       = amt_cur;
  assign topple_o    = ctrl_i.proc & (amt_cur != '0);
  assign sat_o       = ctrl_i.sweep & inj_sat;
  assign rd_height_o = rd_h;
  assign rd_odo_o    = rd_odo;

endmodule

/* rtl/sandpile_avalanche_odometer_core.sv */
// Top level: command sequencer and the row of column cells of the sandpile.
//
// Sandpile with toppling odometer on a GRID_SIDE x GRID_SIDE grid with a sink
// border. The grid is a row of GRID_SIDE column cells, each owning one column
// in a small RAM (height and odometer per row). Relaxation is done in row
// sweeps: every cycle all cells work on the same row, topple it in parallel
// (a cell with h grains fires h/4 times at once), pass their fire counts to
// left and right neighbors, and carry them up and down through the sweep
// window. Sweeps repeat until one sweep sees no cell fire; the final heights
// and odometers do not depend on the toppling order. Per item: command 0
// (clear and load core) writes every row once and then reads out; command
// 2/3 (read) reads the addressed cell; command 1 runs one sweep per parallel
// toppling round plus one quiet sweep, then reads out, so its
// latency is set by the avalanche size. One item is in work at a time; a
// finished result sits in the output register while the next item is
// accepted. After reset a clearing pass over all rows runs before the
// first item is accepted (configuration writes are taken meanwhile).
// Heights saturate at the maximum and raise overflow for that item.
module sandpile_avalanche_odometer_core
  import sao_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CORE_BITS-1:0] cfg_data_i
);

  // Core registers
  logic [CORE_BITS-1:0] core_ul_q, core_ur_q, core_ll_q, core_lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_ul_q <= '0;
      core_ur_q <= '0;
      core_ll_q <= '0;
      core_lr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CORE_UL: core_ul_q <= cfg_data_i;
        CFG_CORE_UR: core_ur_q <= cfg_data_i;
        CFG_CORE_LL: core_ll_q <= cfg_data_i;
        CFG_CORE_LR: core_lr_q <= cfg_data_i;
      endcase
    end
  end

  // Sequencer state
  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 clr_core_q, clr_core_d;
  logic                 inject_q, inject_d;
  logic                 seen_q, seen_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  in_item_t             item_q;
  out_item_t            out_item_q, out_item_d;

  logic                 in_fire, out_load;
  logic                 in_on_grid, on_grid;
  logic [ROW_BITS-1:0]  row_idx, col_idx;
  logic                 any_topple, any_sat;
  logic                 inj_row_hit;
  sao_ctrl_t            ctrl;

  localparam logic [STEP_BITS-1:0] LastRowStep = STEP_BITS'(GRID_SIDE - 1);
  localparam logic [STEP_BITS-1:0] SweepEnd    = STEP_BITS'(GRID_SIDE + 1);

  assign in_fire    = in_valid_i & in_ready_o;
  assign in_on_grid = (int'(in_item_i.row) < GRID_SIDE) && (int'(in_item_i.column) < GRID_SIDE);
  assign on_grid    = (int'(item_q.row) < GRID_SIDE) && (int'(item_q.column) < GRID_SIDE);
  assign row_idx    = ROW_BITS'(item_q.row);
  assign col_idx    = ROW_BITS'(item_q.column);

  // Column cells
  logic [AMT_BITS-1:0]      amt       [GRID_SIDE];
  logic [AMT_BITS-1:0]      amt_left  [GRID_SIDE];
  logic [AMT_BITS-1:0]      amt_right [GRID_SIDE];
  logic [CORE_BITS-1:0]     core_h    [GRID_SIDE];
  logic [GRAINS_W-1:0]      inj_grains[GRID_SIDE];
  logic [HEIGHT_BITS-1:0]   rd_h      [GRID_SIDE];
  logic [ODOMETER_BITS-1:0] rd_odo    [GRID_SIDE];
  logic [GRID_SIDE-1:0]     topple_vec, sat_vec;
  logic                     core_row0, core_row1;

  assign core_row0   = clr_core_q && (ROW_BITS'(step_q) == ROW_BITS'(CENTER));
  assign core_row1   = clr_core_q && (ROW_BITS'(step_q) == ROW_BITS'(CENTER + 1));
  // incoming read data carries row step-1
  assign inj_row_hit = inject_q && (state_q == ST_SWEEP)
                    && (step_q == STEP_BITS'(row_idx) + STEP_BITS'(1));

  for (genvar gi = 0; gi < GRID_SIDE; gi++) begin : g_col
    if (gi > 0) begin : g_l
      assign amt_left[gi] = amt[gi-1];
    end else begin : g_l0
      assign amt_left[gi] = '0;    // sink
    end
    if (gi < GRID_SIDE - 1) begin : g_r
      assign amt_right[gi] = amt[gi+1];
    end else begin : g_r0
      assign amt_right[gi] = '0;   // sink
    end

    assign core_h[gi] = (core_row0 && gi == CENTER)     ? core_ul_q :
                        (core_row0 && gi == CENTER + 1) ? core_ur_q :
                        (core_row1 && gi == CENTER)     ? core_ll_q :
                        (core_row1 && gi == CENTER + 1) ? core_lr_q : '0;

    assign inj_grains[gi] = (inj_row_hit && col_idx == ROW_BITS'(gi)) ? item_q.grains : '0;

    sao_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .load_height_i (core_h[gi]),
      .inject_i      (inj_grains[gi]),
      .amt_left_i    (amt_left[gi]),
      .amt_right_i   (amt_right[gi]),
      .amt_o         (amt[gi]),
      .topple_o      (topple_vec[gi]),
      .sat_o         (sat_vec[gi]),
      .rd_height_o   (rd_h[gi]),
      .rd_odo_o      (rd_odo[gi])
    );
  end

  assign any_topple = |topple_vec;
  assign any_sat    = |sat_vec;

  // Next state
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    clr_core_d = clr_core_q;
    inject_d   = inject_q;
    seen_d     = seen_q;
    ovf_d      = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          step_d   = '0;
          ovf_d    = 1'b0;
          seen_d   = 1'b0;
          inject_d = 1'b0;
          if (in_item_i.cmd == CMD_CLEAR) begin
            state_d    = ST_CLEAR;
            clr_core_d = 1'b1;
          end else if (in_item_i.cmd == CMD_ADD && in_on_grid) begin
            state_d  = ST_SWEEP;
            inject_d = 1'b1;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        step_d = step_q + STEP_BITS'(1);
        if (step_q == LastRowStep) begin
          state_d = clr_core_q ? ST_READ : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        ovf_d  = ovf_q | any_sat;
        seen_d = seen_q | any_topple;
        step_d = step_q + STEP_BITS'(1);
        if (step_q == SweepEnd) begin
          step_d   = '0;
          inject_d = 1'b0;
          seen_d   = 1'b0;
          if (!(seen_q | any_topple)) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    ctrl          = '0;
    ctrl.clr_we   = (state_q == ST_CLEAR);
    ctrl.sweep    = (state_q == ST_SWEEP);
    ctrl.proc     = (state_q == ST_SWEEP) && (step_q >= STEP_BITS'(2));
    ctrl.down_vld = (step_q <= STEP_BITS'(GRID_SIDE));
    ctrl.rd_row   = ((state_q == ST_READ) || (state_q == ST_RESP)) ? row_idx
                                                                    : ROW_BITS'(step_q);
    ctrl.wr_row   = (state_q == ST_CLEAR) ? ROW_BITS'(step_q)
                                          : ROW_BITS'(step_q - STEP_BITS'(2));
    out_load      = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  end

  // Result register
  always_comb begin
    out_item_d              = out_item_q;
    out_valid_d             = out_valid_q & ~out_ready_i;
    if (out_load) begin
      out_valid_d             = 1'b1;
      out_item_d.height       = on_grid ? OUT_H_W'(rd_h[col_idx]) : '0;
      out_item_d.topple_total = on_grid ? OUT_ODO_W'(rd_odo[col_idx]) : '0;
      out_item_d.overflow     = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;   // clearing pass, no core
      step_q      <= '0;
      clr_core_q  <= 1'b0;
      inject_q    <= 1'b0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_core_q  <= clr_core_d;
      inject_q    <= inject_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
